// File: rtl/ssfm_pkg.sv
// ============================================================================
// ssfm_pkg: shared types and constants for the substring search unit
// Sizes of the lanes, the history line, the byte counter and the needle,
// plus configuration register indexes.
// ============================================================================
package ssfm_pkg;

    localparam int NEEDLE_MAX    = 32;
    localparam int LANES         = 8;
    localparam int POSITION_BITS = 24;

    // fixed field widths
    localparam int DATA_W     = 64;
    localparam int COUNT_W    = 4;
    localparam int MATCH_POS_W = 24;
    localparam int CFG_DATA_W = 64;
    localparam int CFG_IDX_W  = 3;
    localparam int LEN_REG_W  = 6;
    localparam int NEEDLE_REGS = 4;

    // derived sizes
    localparam int NEEDLE_CAP = (NEEDLE_MAX < 32) ? NEEDLE_MAX : 32;
    localparam int BYTE_CAP   = (LANES < 8) ? LANES : 8;
    localparam int HIST_DEPTH = NEEDLE_MAX - 1;
    localparam int BUF_DEPTH  = HIST_DEPTH + LANES;
    localparam int LANE_W     = (LANES > 1) ? $clog2(LANES) : 1;
    localparam int NIDX_W     = (NEEDLE_CAP > 1) ? $clog2(NEEDLE_CAP) : 1;
    localparam int CNT_W      = POSITION_BITS + 1;

    localparam logic [CNT_W-1:0] COUNT_MAX = {CNT_W{1'b1}};
    localparam logic [CNT_W:0]   POS_LIM   = (CNT_W+1)'(1) << POSITION_BITS;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_NEEDLE_LENGTH  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_NEEDLE_BYTES_0 = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_NEEDLE_BYTES_1 = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_NEEDLE_BYTES_2 = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_NEEDLE_BYTES_3 = 3'd4;

    typedef logic [7:0]                  t_byte;
    typedef logic [NEEDLE_CAP-1:0][7:0]  t_win;
    typedef logic [NEEDLE_CAP-1:0]       t_mask;
    typedef logic [LANES-1:0]            t_lane_vec;
    typedef logic [CNT_W-1:0]            t_count;
    typedef logic [LEN_REG_W-1:0]        t_len;

    // what the merging stage found over all lanes
    typedef struct packed {
        logic           hit;
        logic [CNT_W:0] start;
        logic           ovf;
    } t_merge;

    // low MATCH_POS_W bits of a counter-wide value, zero extended if narrower
    function automatic logic [MATCH_POS_W-1:0] to_pos(input logic [CNT_W:0] v);
        logic [CNT_W+MATCH_POS_W:0] t;
        t = {{MATCH_POS_W{1'b0}}, v};
        return t[MATCH_POS_W-1:0];
    endfunction

endpackage

// File: rtl/ssfm_in_if.sv
// ============================================================================
// ssfm_in_if: haystack chunk channel
// Valid/ready channel carrying one chunk of up to eight haystack bytes.
// ============================================================================
interface ssfm_in_if;
    logic                          valid;
    logic                          ready;
    logic [ssfm_pkg::DATA_W-1:0]   data_bytes;
    logic [ssfm_pkg::COUNT_W-1:0]  byte_count;
    logic                          last_chunk;

    modport source (output valid, output data_bytes, output byte_count,
                    output last_chunk, input ready);
    modport sink   (input valid, input data_bytes, input byte_count,
                    input last_chunk, output ready);
endinterface

// File: rtl/ssfm_out_if.sv
// ============================================================================
// ssfm_out_if: search result channel
// Valid/ready channel carrying one found / not-found report.
// ============================================================================
interface ssfm_out_if;
    logic                              valid;
    logic                              ready;
    logic                              found;
    logic [ssfm_pkg::MATCH_POS_W-1:0]  match_position;
    logic                              position_overflow;

    modport source (output valid, output found, output match_position,
                    output position_overflow, input ready);
    modport sink   (input valid, input found, input match_position,
                    input position_overflow, output ready);
endinterface

// File: rtl/ssfm_lane.sv
// ============================================================================
// ssfm_lane: one match lane
// Compares the window that ends at this lane's byte against the
// end-aligned needle, over the needle's length only.
// ============================================================================
module ssfm_lane (
    input  ssfm_pkg::t_win  i_window,
    input  ssfm_pkg::t_win  i_needle,
    input  ssfm_pkg::t_mask i_len_mask,
    input  logic            i_enable,
    output logic            o_hit
);
    import ssfm_pkg::*;

    t_mask eq;

    always_comb begin
        for (int m = 0; m < NEEDLE_CAP; m++) begin
            eq[m] = (i_window[m] == i_needle[m]) || !i_len_mask[m];
        end
    end

    assign o_hit = i_enable && (&eq);

endmodule

// File: rtl/ssfm_merge.sv
// ============================================================================
// ssfm_merge: lane merge
// Picks the earliest hitting lane and turns it into a start offset with
// its overflow flag.
// ============================================================================
module ssfm_merge (
    input  ssfm_pkg::t_lane_vec i_hits,
    input  ssfm_pkg::t_count    i_bytes_seen,
    input  ssfm_pkg::t_len      i_len,
    output ssfm_pkg::t_merge    o_merge
);
    import ssfm_pkg::*;

    logic [LANE_W-1:0] idx;
    logic [CNT_W:0]    sum;

    // earliest lane wins: scan from the top so the lowest hit is kept
    always_comb begin
        idx = '0;
        for (int j = LANES - 1; j >= 0; j--) begin
            if (i_hits[j]) begin
                idx = LANE_W'(j);
            end
        end
    end

    assign sum = {1'b0, i_bytes_seen} + (CNT_W+1)'(idx);

    always_comb begin
        o_merge.hit   = |i_hits;
        o_merge.start = sum + (CNT_W+1)'(1) - (CNT_W+1)'(i_len);
        o_merge.ovf   = (o_merge.start >= POS_LIM) || (sum >= {1'b0, COUNT_MAX});
    end

endmodule

// File: rtl/substring_search_first_match_unit.sv
// ============================================================================
// substring_search_first_match_unit: streaming first-occurrence search
// Finds the first place a configured needle of 1 to 32 bytes starts in a
// haystack streamed as chunks of up to 8 bytes.
// ============================================================================
// Usage: program the needle length and needle bytes while the unit is idle,
// then stream a haystack as chunk words, earliest byte in bits 7:0, with
// last_chunk on the final word. The unit takes one chunk word every clock
// cycle while ready is high; the word is searched in the cycle it is accepted
// by one eight-lane compare against a 31-byte history, and its report, if
// any, is shown from the next cycle in the output register. Input ready
// drops only while a report sits in the output register and the sink holds
// it off. Per stream there is exactly one report: found=1 with the start
// offset on the first full match (the rest of the stream is then swallowed),
// or found=0 on the last chunk. A match always lies inside bytes received.
// Offsets that do not fit in 24 bits set position_overflow, and a found
// position then reads all ones. A needle length of zero acts as 1, lengths
// above 32 act as 32; byte counts above 8 act as 8, a count of zero carries
// no bytes but last_chunk still closes the stream.
// ============================================================================
module substring_search_first_match_unit (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [ssfm_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [ssfm_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    ssfm_in_if.sink                          i_in,
    ssfm_out_if.source                       o_out
);
    import ssfm_pkg::*;

    // configuration
    t_len                     r_needle_length;
    logic [DATA_W-1:0]        r_needle [NEEDLE_REGS];

    // stream state
    logic [HIST_DEPTH-1:0][7:0] r_hist, n_hist;
    t_count                   r_bytes_seen, n_bytes_seen;
    logic                     r_reported, n_reported;

    // output register
    logic                     r_out_valid, n_out_valid;
    logic                     r_found, n_found;
    logic [MATCH_POS_W-1:0]   r_pos, n_pos;
    logic                     r_ovf, n_ovf;

    logic                     accept;
    t_len                     eff_len;
    logic [COUNT_W-1:0]       nbytes;
    logic [NEEDLE_CAP-1:0][7:0] needle_flat;
    t_win                     needle_al;
    t_mask                    len_mask;
    logic [BUF_DEPTH-1:0][7:0] win_buf;
    logic [LANES*8+DATA_W-1:0] data_ext;
    t_lane_vec                lane_hit;
    t_merge                   merge;
    logic [CNT_W:0]           seen_sum;

    // ------------------------------------------------------------------
    // configuration writes
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_needle_length <= LEN_REG_W'(1);
            for (int r = 0; r < NEEDLE_REGS; r++) begin
                r_needle[r] <= '0;
            end
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_NEEDLE_LENGTH:  r_needle_length <= i_cfg_data[LEN_REG_W-1:0];
                CFG_NEEDLE_BYTES_0: r_needle[0] <= i_cfg_data;
                CFG_NEEDLE_BYTES_1: r_needle[1] <= i_cfg_data;
                CFG_NEEDLE_BYTES_2: r_needle[2] <= i_cfg_data;
                CFG_NEEDLE_BYTES_3: r_needle[3] <= i_cfg_data;
                default: ;   // drop writes beyond the register list
            endcase
        end
    end

    // clamp the needle length into 1..NEEDLE_CAP
    always_comb begin
        if (r_needle_length == '0) begin
            eff_len = LEN_REG_W'(1);
        end else if (r_needle_length > LEN_REG_W'(NEEDLE_CAP)) begin
            eff_len = LEN_REG_W'(NEEDLE_CAP);
        end else begin
            eff_len = r_needle_length;
        end
    end

    // clamp the byte count to what the lanes hold
    assign nbytes = (i_in.byte_count > COUNT_W'(BYTE_CAP)) ? COUNT_W'(BYTE_CAP)
                                                           : i_in.byte_count;

    // ------------------------------------------------------------------
    // end-align the needle: entry m holds needle byte len-1-m, so every
    // lane compares its newest byte against the needle's last byte
    // ------------------------------------------------------------------
    always_comb begin
        logic [LEN_REG_W:0] idx;
        for (int k = 0; k < NEEDLE_CAP; k++) begin
            needle_flat[k] = r_needle[k / 8][8 * (k % 8) +: 8];
        end
        for (int m = 0; m < NEEDLE_CAP; m++) begin
            idx          = {1'b0, eff_len} - (LEN_REG_W+1)'(1) - (LEN_REG_W+1)'(m);
            len_mask[m]  = (LEN_REG_W+1)'(m) < {1'b0, eff_len};
            needle_al[m] = len_mask[m] ? needle_flat[idx[NIDX_W-1:0]] : 8'h00;
        end
    end

    // ------------------------------------------------------------------
    // history followed by the new chunk, oldest byte at index 0
    // ------------------------------------------------------------------
    assign data_ext = {(LANES*8)'(0), i_in.data_bytes};

    always_comb begin
        for (int i = 0; i < HIST_DEPTH; i++) begin
            win_buf[i] = r_hist[i];
        end
        for (int j = 0; j < LANES; j++) begin
            win_buf[HIST_DEPTH + j] = data_ext[8 * j +: 8];
        end
    end

    // ------------------------------------------------------------------
    // lanes: lane j checks the window that ends at chunk byte j
    // ------------------------------------------------------------------
    for (genvar j = 0; j < LANES; j++) begin : g_lane
        t_win lane_win;
        logic lane_en;

        always_comb begin
            for (int m = 0; m < NEEDLE_CAP; m++) begin
                lane_win[m] = win_buf[HIST_DEPTH + j - m];
            end
        end

        // byte must be present and the window must lie inside the stream
        assign lane_en = (nbytes > COUNT_W'(j)) &&
                         (({1'b0, r_bytes_seen} + (CNT_W+1)'(j + 1))
                          >= (CNT_W+1)'(eff_len));

        ssfm_lane u_lane (
            .i_window   (lane_win),
            .i_needle   (needle_al),
            .i_len_mask (len_mask),
            .i_enable   (lane_en),
            .o_hit      (lane_hit[j])
        );
    end

    ssfm_merge u_merge (
        .i_hits       (lane_hit),
        .i_bytes_seen (r_bytes_seen),
        .i_len        (eff_len),
        .o_merge      (merge)
    );

    // ------------------------------------------------------------------
    // handshake: the output register parts the two sides
    // ------------------------------------------------------------------
    assign i_in.ready = !r_out_valid || o_out.ready;
    assign accept     = i_in.valid && i_in.ready;

    assign seen_sum = {1'b0, r_bytes_seen} + (CNT_W+1)'(nbytes);

    always_comb begin
        n_hist       = r_hist;
        n_bytes_seen = r_bytes_seen;
        n_reported   = r_reported;
        n_out_valid  = r_out_valid && !o_out.ready;
        n_found      = r_found;
        n_pos        = r_pos;
        n_ovf        = r_ovf;

        if (accept) begin
            if (r_reported) begin
                // swallow the rest of a reported stream
                if (i_in.last_chunk) begin
                    n_bytes_seen = '0;
                    n_reported   = 1'b0;
                end
            end else if (merge.hit) begin
                n_out_valid = 1'b1;
                n_found     = 1'b1;
                n_ovf       = merge.ovf;
                n_pos       = merge.ovf ? to_pos(POS_LIM - (CNT_W+1)'(1))
                                        : to_pos(merge.start);
                if (i_in.last_chunk) begin
                    n_bytes_seen = '0;
                    n_reported   = 1'b0;
                end else begin
                    n_reported   = 1'b1;
                end
            end else begin
                // advance the history by the number of new bytes
                for (int i = 0; i < HIST_DEPTH; i++) begin
                    for (int s = 0; s <= BYTE_CAP; s++) begin
                        if (nbytes == COUNT_W'(s)) begin
                            n_hist[i] = win_buf[i + s];
                        end
                    end
                end
                n_bytes_seen = (seen_sum > {1'b0, COUNT_MAX}) ? COUNT_MAX
                                                              : seen_sum[CNT_W-1:0];
                if (i_in.last_chunk) begin
                    n_out_valid  = 1'b1;
                    n_found      = 1'b0;
                    n_pos        = '0;
                    n_ovf        = {1'b0, n_bytes_seen} > POS_LIM;
                    n_bytes_seen = '0;
                    n_reported   = 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hist       <= '0;
            r_bytes_seen <= '0;
            r_reported   <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_hist       <= n_hist;
            r_bytes_seen <= n_bytes_seen;
            r_reported   <= n_reported;
            r_out_valid  <= n_out_valid;
        end
    end

    // result payload, held while the sink stalls
    always_ff @(posedge i_clk) begin
        r_found <= n_found;
        r_pos   <= n_pos;
        r_ovf   <= n_ovf;
    end

    assign o_out.valid             = r_out_valid;
    assign o_out.found             = r_found;
    assign o_out.match_position    = r_pos;
    assign o_out.position_overflow = r_ovf;

endmodule
